FILE: rtl/orlt_pkg.sv
// shared constants, types and helpers for the ordered record list table
package orlt_pkg;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 32;

  // stored payload bits: payload field is 32 bits wide on the ports
  localparam int PAY_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  // entry count, able to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);
  // common width for comparing a cell position against the 8-bit position field
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  // cells per gather group
  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  localparam int ID_W  = 32;
  localparam int POS_W = 8;

  typedef enum logic [3:0] {
    CMD_INS_HEAD   = 4'd0,
    CMD_INS_TAIL   = 4'd1,
    CMD_INS_SORTED = 4'd2,
    CMD_RM_HEAD    = 4'd3,
    CMD_RM_TAIL    = 4'd4,
    CMD_RM_ID      = 4'd5,
    CMD_READ_POS   = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_GATHER,
    S_DONE
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   key;
    logic [PAY_W-1:0]  pay;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic              cmp_en;
    logic              apply_en;
    logic              write_en;
  } cell_ctl_t;

  // signed less-than on two's complement ids
  function automatic logic id_less(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
    id_less = $signed(a) < $signed(b);
  endfunction

endpackage

FILE: rtl/orlt_cell.sv
// one list entry: holds a record, compares it against the key, shifts with its neighbors
module orlt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [orlt_pkg::CNT_W-1:0]  cell_index,
  input  orlt_pkg::cell_ctl_t         ctl,
  input  logic                        keep_in,
  output logic                        keep_out,
  input  logic [orlt_pkg::ID_W-1:0]   left_id,
  input  logic [orlt_pkg::PAY_W-1:0]  left_pay,
  input  logic [orlt_pkg::ID_W-1:0]   right_id,
  input  logic [orlt_pkg::PAY_W-1:0]  right_pay,
  output logic [orlt_pkg::ID_W-1:0]   rec_id,
  output logic [orlt_pkg::PAY_W-1:0]  rec_pay,
  output logic                        hit,
  output logic [orlt_pkg::ID_W-1:0]   hit_id,
  output logic [orlt_pkg::PAY_W-1:0]  hit_pay
);
  import orlt_pkg::*;

  logic lt, eq, gt;
  logic valid, before_last, before_pos;
  logic cond, stay, at_w;

  always_comb begin
    valid       = cell_index < ctl.count;
    before_last = (cell_index + CNT_W'(1)) < ctl.count;
    before_pos  = (CMP_W'(cell_index) + CMP_W'(1)) < CMP_W'(ctl.pos);
    case (ctl.cmd)
      CMD_INS_TAIL:   cond = valid;
      CMD_INS_SORTED: cond = (cell_index == '0) ? (valid & ~gt) : (valid & lt);
      CMD_RM_TAIL:    cond = before_last;
      CMD_RM_ID:      cond = valid & ~eq;
      CMD_FIND:       cond = valid & ~eq;
      CMD_READ_POS:   cond = before_pos;
      default:        cond = 1'b0;
    endcase
    // cells ahead of the working position keep their record
    stay     = keep_in & cond;
    keep_out = stay;
    at_w     = keep_in & ~stay;
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt <= id_less(rec_id, ctl.key);
      eq <= rec_id == ctl.key;
      gt <= id_less(ctl.key, rec_id);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_en && !stay) begin
      case (ctl.cmd)
        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORTED: begin
          rec_id  <= at_w ? ctl.key : left_id;
          rec_pay <= at_w ? ctl.pay : left_pay;
        end
        CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_ID: begin
          rec_id  <= right_id;
          rec_pay <= right_pay;
        end
        default: begin
          rec_id  <= rec_id;
          rec_pay <= rec_pay;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.apply_en) begin
      hit <= at_w & valid;
    end
  end

  // records are captured before any shift so read and find see the old list
  always_ff @(posedge clk) begin
    if (ctl.apply_en) begin
      hit_id  <= (at_w & valid) ? rec_id : '0;
      hit_pay <= (at_w & valid) ? rec_pay : '0;
    end
  end

endmodule

FILE: rtl/ordered_record_list_table_unit.sv
// top level of the ordered record list table: controller, cell chain and result gather
// The block keeps up to DEPTH records (a signed 32-bit id and a payload) in list
// order inside a row of identical cells, each cell holding one record and
// trading records with its left and right neighbors. Every command runs four
// steps from its input transfer to its result being registered: all cells
// compare their id against the key (S_CMP), the keep flag ripples down the
// chain and every cell shifts or loads together (S_APPLY), groups of eight
// cells merge their hit flags and records (S_GATHER), and the groups are
// combined into the output register (S_DONE). A new command is taken once the
// previous one has reached the output register, and a waiting result does not
// stop the next command from starting; a result that still waits holds the
// block in its last step until it is taken.
// Each command gives exactly one result transfer with the success flag, the
// record read or found (zero otherwise) and the count after the command. There
// is no clearing pass after reset: only the count, the state and the valid and hit flags are cleared.
module ordered_record_list_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[3:0], item_id[35:4], item_payload[67:36], position[75:68], zero[79:76]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // success[0], found_id[32:1], found_payload[64:33], entry_count[71:65]
  output logic [71:0] m_tdata
);
  import orlt_pkg::*;

  state_t state, state_next;

  // command held for the whole operation
  cmd_t              op_cmd;
  logic [ID_W-1:0]   op_key;
  logic [PAY_W-1:0]  op_pay;
  logic [POS_W-1:0]  op_pos;
  logic [CNT_W-1:0]  count;

  logic              op_ok;   // insert had room, or clear
  logic              full;
  logic              is_insert, is_remove, is_lookup;

  logic              cmp_en, apply_en, gather_en, load_out;
  cell_ctl_t         ctl;

  // cell chain wiring
  logic [DEPTH:0]            keep;
  logic [DEPTH-1:0]          cell_hit;
  logic [ID_W-1:0]           cell_id   [DEPTH];
  logic [PAY_W-1:0]          cell_pay  [DEPTH];
  logic [ID_W-1:0]           cell_hid  [DEPTH];
  logic [PAY_W-1:0]          cell_hpay [DEPTH];

  // gather groups
  logic [NGRP-1:0]   grp_hit;
  logic [ID_W-1:0]   grp_id  [NGRP];
  logic [PAY_W-1:0]  grp_pay [NGRP];

  logic              any_hit;
  logic [ID_W-1:0]   all_id;
  logic [PAY_W-1:0]  all_pay;
  logic              res_ok;
  logic              res_show;
  logic [CNT_W-1:0]  count_next;

  // ---------------------------------------------------------------------------
  // command decode
  // ---------------------------------------------------------------------------
  always_comb begin
    full      = count >= CNT_W'(DEPTH);
    is_insert = (op_cmd == CMD_INS_HEAD) || (op_cmd == CMD_INS_TAIL) ||
                (op_cmd == CMD_INS_SORTED);
    is_remove = (op_cmd == CMD_RM_HEAD) || (op_cmd == CMD_RM_TAIL) ||
                (op_cmd == CMD_RM_ID);
    is_lookup = (op_cmd == CMD_READ_POS) || (op_cmd == CMD_FIND);
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmp_en     = 1'b0;
    apply_en   = 1'b0;
    gather_en  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmp_en     = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        apply_en   = 1'b1;
        state_next = S_GATHER;
      end
      S_GATHER: begin
        gather_en  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait here while the output register still holds an untaken result
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // input transfer captures the command
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_cmd <= cmd_t'(s_tdata[3:0]);
      op_key <= s_tdata[35:4];
      op_pay <= s_tdata[36 +: PAY_W];
      op_pos <= s_tdata[75:68];
    end
  end

  // insert into a full list changes nothing
  always_ff @(posedge clk) begin
    if (apply_en) begin
      op_ok <= (is_insert && !full) || (op_cmd == CMD_CLEAR);
    end
  end

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl.cmd      = op_cmd;
    ctl.key      = op_key;
    ctl.pay      = op_pay;
    ctl.pos      = op_pos;
    ctl.count    = count;
    ctl.cmp_en   = cmp_en;
    ctl.apply_en = apply_en;
    // removals that find nothing only shift cells past the tail
    ctl.write_en = apply_en && ((is_insert && !full) || is_remove);
  end

  assign keep[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  l_id, r_id;
    logic [PAY_W-1:0] l_pay, r_pay;

    // chain ends feed the cell its own record; those values fall off the list
    if (i == 0) begin : g_head
      assign l_id  = cell_id[i];
      assign l_pay = cell_pay[i];
    end else begin : g_mid_l
      assign l_id  = cell_id[i-1];
      assign l_pay = cell_pay[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_id  = cell_id[i];
      assign r_pay = cell_pay[i];
    end else begin : g_mid_r
      assign r_id  = cell_id[i+1];
      assign r_pay = cell_pay[i+1];
    end

    orlt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (CNT_W'(i)),
      .ctl        (ctl),
      .keep_in    (keep[i]),
      .keep_out   (keep[i+1]),
      .left_id    (l_id),
      .left_pay   (l_pay),
      .right_id   (r_id),
      .right_pay  (r_pay),
      .rec_id     (cell_id[i]),
      .rec_pay    (cell_pay[i]),
      .hit        (cell_hit[i]),
      .hit_id     (cell_hid[i]),
      .hit_pay    (cell_hpay[i])
    );
  end

  // ---------------------------------------------------------------------------
  // gather: at most one cell hits, so or-merging its record is exact
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic             h;
    logic [ID_W-1:0]  gid;
    logic [PAY_W-1:0] gpay;

    always_comb begin
      h    = 1'b0;
      gid  = '0;
      gpay = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          h    = h | cell_hit[g*GRP+k];
          gid  = gid | cell_hid[g*GRP+k];
          gpay = gpay | cell_hpay[g*GRP+k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (gather_en) begin
        grp_hit[g] <= h;
        grp_id[g]  <= gid;
        grp_pay[g] <= gpay;
      end
    end
  end

  always_comb begin
    any_hit = |grp_hit;
    all_id  = '0;
    all_pay = '0;
    for (int g = 0; g < NGRP; g++) begin
      all_id  = all_id | grp_id[g];
      all_pay = all_pay | grp_pay[g];
    end
    // position zero lands on the head cell but never names an entry
    res_ok   = op_ok ||
               (any_hit && (is_remove || is_lookup) &&
                !((op_cmd == CMD_READ_POS) && (op_pos == '0)));
    res_show = res_ok && is_lookup;

    count_next = count;
    if (op_cmd == CMD_CLEAR) begin
      count_next = '0;
    end else if (is_insert && op_ok) begin
      count_next = count + CNT_W'(1);
    end else if (is_remove && res_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // count follows the list once the result is known
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_out) begin
      count <= count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata[0]     <= res_ok;
      m_tdata[32:1]  <= res_show ? all_id : '0;
      m_tdata[64:33] <= res_show ? 32'(all_pay) : 32'd0;
      m_tdata[71:65] <= 7'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  // the count never passes the cell count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // the keep chain can hand the working position to one cell at most
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_GATHER |-> $onehot0(cell_hit))
    else $error("more than one cell hit");

  // every accepted command reaches the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!m_tvalid || m_tready) |=> m_tvalid && (state == S_IDLE))
    else $error("finished command not loaded into output");

  // a command is only taken while nothing is in progress
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CMP)
    else $error("input transfer outside idle");
`endif

endmodule
